FILE: hw/rtl/mcdbt_pkg.sv
// Package for the mip chain dirty box tracker.
// Holds the command codes, sequencer states and fixed field widths.
// No dependencies.
package mcdbt_pkg;

	localparam int FIELD_W = 16;
	localparam int LEVEL_W = 4;

	typedef enum logic [1:0] {
		CMD_MARK  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_OTHER = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MARK,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/mip_chain_dirty_box_tracker_top.sv
// Mip chain dirty box tracker, top level.
// Box store, level walk sequencer and output register.
// Depends on mcdbt_pkg.
//
// Usage:
//   Requests enter on the in_valid/in_ready channel: mark a changed base
//   rectangle, clear one level's box, or read one level's box. Each request
//   gives one result on the out_valid/out_ready channel: the addressed
//   level's box after the request, its dirty flag and the level count.
//   Base width and height are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle, which the block
//   itself does not enforce. Writing them changes no stored box. The boxes
//   sit in one synchronous memory with a registered read. A mark walks
//   levels 1 to levels_in_use - 1, reading one level a cycle while the
//   previous level's merged box is written back.
//   in_ready is high only while the block is idle, so a new request is taken
//   only once the previous one is finished. A finished result waits in the
//   output register, and the next request is taken meanwhile; that request
//   stalls before its result only while the waiting result is unaccepted.
//   Reset empties every box (per-level valid bits) and sets both base sizes
//   to 1.
module mip_chain_dirty_box_tracker_top
	import mcdbt_pkg::*;
#(
	parameter int MAX_LEVELS  = 12,
	parameter int COORD_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [FIELD_W-1:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [FIELD_W-1:0] area_x,
	input  logic [FIELD_W-1:0] area_y,
	input  logic [FIELD_W-1:0] area_width,
	input  logic [FIELD_W-1:0] area_height,
	input  logic [LEVEL_W-1:0] target_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] box_left,
	output logic [FIELD_W-1:0] box_top,
	output logic [FIELD_W-1:0] box_right,
	output logic [FIELD_W-1:0] box_bottom,
	output logic               level_dirty,
	output logic [LEVEL_W-1:0] levels_in_use
);

	localparam int CW = COORD_WIDTH;
	localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam logic [FIELD_W:0] COORD_MAX = (FIELD_W + 1)'((1 << CW) - 1);

	typedef struct packed {
		logic [CW-1:0] left;
		logic [CW-1:0] top;
		logic [CW-1:0] right;
		logic [CW-1:0] bottom;
	} box_t;

	// configuration
	logic [FIELD_W-1:0] base_w_q, base_h_q;
	logic [FIELD_W-1:0] big;
	logic [3:0]         flog2;
	logic [4:0]         n_raw;
	logic [LW-1:0]      lvl_n;

	// sequencer and request
	state_t             state_q, state_d;
	logic [LEVEL_W-1:0] tgt_q;
	logic               tgt_ok, tgt_ok_q;
	logic [LW-1:0]      lvl_q;
	box_t               c_q, c_n, c_init;
	logic [FIELD_W-1:0] tw_q, th_q, tw_n, th_n, tw_h, th_h;
	logic [CW:0]        r_h, b_h;
	logic               accept, issue;

	// memory
	box_t               boxes_q [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] bvalid_q;
	box_t               rd_box_q;
	logic               rd_vld_q;
	logic               mem_re, mem_we;
	logic [AW-1:0]      mem_raddr;
	box_t               stored, merged, res_box;
	logic               stored_empty;

	// write-back stage
	logic               wr_vld_s1;
	logic [AW-1:0]      addr_s1;
	box_t               box_s1;

	// output register
	logic               out_valid_q, out_load;
	box_t               out_box_q;
	logic               out_dirty_q;
	logic [LEVEL_W-1:0] out_lvls_q;

	function automatic logic [CW-1:0] sat_coord(input logic [FIELD_W:0] v);
		return (v > COORD_MAX) ? COORD_MAX[CW-1:0] : v[CW-1:0];
	endfunction

	// level count from the base size
	always_comb begin
		big   = (base_w_q > base_h_q) ? base_w_q : base_h_q;
		flog2 = '0;
		for (int i = 1; i < FIELD_W; i++) begin
			if (big[i])
				flog2 = 4'(i);
		end
		n_raw = 5'd1 + {1'b0, flog2};
		lvl_n = (n_raw > 5'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(n_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_w_q <= 16'd1;
			base_h_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_index)
				base_h_q <= cfg_data;
			else
				base_w_q <= cfg_data;
		end
	end

	assign accept = in_valid && in_ready;
	assign tgt_ok = (target_level != '0) && ({1'b0, target_level} < 5'(MAX_LEVELS));

	// base rectangle with saturated edges
	always_comb begin
		c_init.left   = sat_coord({1'b0, area_x});
		c_init.top    = sat_coord({1'b0, area_y});
		c_init.right  = sat_coord({1'b0, area_x} + {1'b0, area_width});
		c_init.bottom = sat_coord({1'b0, area_y} + {1'b0, area_height});
	end

	// halve the running box to the next level and clamp to its size
	always_comb begin
		tw_h     = tw_q >> 1;
		th_h     = th_q >> 1;
		tw_n     = (tw_h == '0) ? 16'd1 : tw_h;
		th_n     = (th_h == '0) ? 16'd1 : th_h;
		r_h      = ({1'b0, c_q.right} + (CW + 1)'(1)) >> 1;
		b_h      = ({1'b0, c_q.bottom} + (CW + 1)'(1)) >> 1;
		c_n.left = c_q.left >> 1;
		c_n.top  = c_q.top >> 1;
		c_n.right  = ((FIELD_W + 1)'(r_h) < {1'b0, tw_n}) ? r_h[CW-1:0] : CW'(tw_n);
		c_n.bottom = ((FIELD_W + 1)'(b_h) < {1'b0, th_n}) ? b_h[CW-1:0] : CW'(th_n);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		issue     = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = tgt_q[AW-1:0];
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = (cmd_t'(command) == CMD_MARK) ? ST_MARK : ST_READ;
			end
			ST_MARK: begin
				if (lvl_q < lvl_n) begin
					issue     = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = lvl_q[AW-1:0];
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				mem_re  = tgt_ok_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q    <= '0;
			tgt_ok_q <= 1'b0;
			lvl_q    <= '0;
		end else if (accept) begin
			tgt_q    <= target_level;
			tgt_ok_q <= tgt_ok;
			lvl_q    <= LW'(1);
		end else if (issue) begin
			lvl_q <= lvl_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q  <= c_init;
			tw_q <= base_w_q;
			th_q <= base_h_q;
		end else if (issue) begin
			c_q  <= c_n;
			tw_q <= tw_n;
			th_q <= th_n;
		end
	end

	// write-back stage: merge with the box read for this level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wr_vld_s1 <= 1'b0;
		else
			wr_vld_s1 <= issue;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= lvl_q[AW-1:0];
			box_s1  <= c_n;
		end
	end

	assign stored       = rd_vld_q ? rd_box_q : '0;
	assign stored_empty = (stored.left == stored.right) || (stored.top == stored.bottom);
	assign mem_we       = wr_vld_s1;

	always_comb begin
		if (stored_empty) begin
			merged = box_s1;
		end else begin
			merged.left   = (box_s1.left < stored.left) ? box_s1.left : stored.left;
			merged.top    = (box_s1.top < stored.top) ? box_s1.top : stored.top;
			merged.right  = (box_s1.right > stored.right) ? box_s1.right : stored.right;
			merged.bottom = (box_s1.bottom > stored.bottom) ? box_s1.bottom : stored.bottom;
		end
	end

	// box memory
	always_ff @(posedge clk) begin
		if (mem_we)
			boxes_q[addr_s1] <= merged;
		if (mem_re)
			rd_box_q <= boxes_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				bvalid_q[addr_s1] <= 1'b1;
			if (accept && cmd_t'(command) == CMD_CLEAR && tgt_ok)
				bvalid_q[target_level[AW-1:0]] <= 1'b0;
			if (mem_re)
				rd_vld_q <= bvalid_q[mem_raddr];
		end
	end

	// output register
	assign res_box = (rd_vld_q && tgt_ok_q) ? rd_box_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_box_q   <= res_box;
			out_dirty_q <= (res_box.left != res_box.right) && (res_box.top != res_box.bottom);
			out_lvls_q  <= LEVEL_W'(lvl_n);
		end
	end

	assign out_valid     = out_valid_q;
	assign box_left      = FIELD_W'(out_box_q.left);
	assign box_top       = FIELD_W'(out_box_q.top);
	assign box_right     = FIELD_W'(out_box_q.right);
	assign box_bottom    = FIELD_W'(out_box_q.bottom);
	assign level_dirty   = out_dirty_q;
	assign levels_in_use = out_lvls_q;

	a_idle_no_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_vld_s1)
		else $error("write-back pending while idle");

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && mem_we) |-> (mem_raddr != addr_s1))
		else $error("read and write-back hit the same entry");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK) |-> (lvl_q <= lvl_n && lvl_q != '0))
		else $error("level walk out of range");

	a_writeback_level: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> (addr_s1 != '0))
		else $error("write-back to level zero");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_load) |=> $stable(res_box))
		else $error("read data lost while output stalled");

endmodule
